>>> hw/rtl/fcd_pkg.sv
package fcd_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 1024;
    localparam int PALETTE_ENTRIES = 256;
    localparam int Q_DEPTH         = 8;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);
    localparam int TDATA_W         = 88;

    localparam logic [2:0] KIND_FILL  = 3'd0;
    localparam logic [2:0] KIND_WORD  = 3'd1;
    localparam logic [2:0] KIND_PAL   = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_FRAME_TYPE  = 3'd0;
    localparam logic [2:0] ERR_FRAME_SHORT = 3'd1;
    localparam logic [2:0] ERR_HDR_PAST    = 3'd2;
    localparam logic [2:0] ERR_CHUNK_SHORT = 3'd3;
    localparam logic [2:0] ERR_CHUNK_PAST  = 3'd4;

    localparam logic       CFG_WIDTH  = 1'b0;
    localparam logic       CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [19:0] address;
        logic [20:0] count;
        logic [15:0] fill_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  error_code;
        logic        last_of_item;
    } t_res;

    typedef struct packed {
        logic [1:0] num;
        t_res       r0;
        t_res       r1;
    } t_res_pair;

endpackage

>>> hw/rtl/fcd_parser.sv
module fcd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output fcd_pkg::t_res_pair o_res
);
    import fcd_pkg::*;

    typedef enum logic [4:0] {
        PH_FH_SIZE = 5'd0, PH_FH_TYPE = 5'd1, PH_FH_COUNT = 5'd2, PH_FH_RESV = 5'd3,
        PH_CH_SIZE = 5'd4, PH_CH_TYPE = 5'd5, PH_FRAME_TAIL = 5'd6, PH_SKIP = 5'd7,
        PH_COL_COUNT = 5'd8, PH_COL_SKIP = 5'd9, PH_COL_NUM = 5'd10, PH_COL_RGB = 5'd11,
        PH_DL_LINES = 5'd12, PH_DL_OPT = 5'd13, PH_DL_COLSKIP = 5'd14, PH_DL_TYPE = 5'd15,
        PH_DL_LIT = 5'd16, PH_DL_WORD = 5'd17, PH_BR_LINE = 5'd18, PH_BR_SIZE = 5'd19,
        PH_BR_COLOR = 5'd20, PH_BR_LIT = 5'd21, PH_LITERAL = 5'd22
    } t_phase;

    localparam logic [2:0] CK_OTHER = 3'd0;
    localparam logic [2:0] CK_C256  = 3'd1;
    localparam logic [2:0] CK_C64   = 3'd2;
    localparam logic [2:0] CK_DELTA = 3'd3;
    localparam logic [2:0] CK_BRUN  = 3'd4;
    localparam logic [2:0] CK_LIT   = 3'd5;
    localparam logic [2:0] CK_BLACK = 3'd6;
    localparam logic [23:0] POS_CAP = 24'hFFFFFF;

    function automatic logic [23:0] f_sat(input logic [27:0] v);
        return (v > 28'(POS_CAP)) ? POS_CAP : v[23:0];
    endfunction

    t_phase      r_ph, n_ph;
    logic [31:0] r_fbl, n_fbl, r_cbl, n_cbl, r_fa, n_fa;
    logic [15:0] r_chl, n_chl, r_lines, n_lines, r_pk, n_pk, r_pal, n_pal, r_hold, n_hold;
    logic [2:0]  r_ck, n_ck, r_fbi, n_fbi;
    logic [23:0] r_lb, n_lb, r_col, n_col;
    logic [7:0]  r_lit, n_lit;
    logic        r_err, n_err;
    logic [10:0] r_cfg_w, r_cfg_h;
    logic [20:0] r_bsz;

    logic [10:0] w, h;
    logic [31:0] fa_new;
    logic [2:0]  fbi_inc;
    logic [24:0] a;
    logic [20:0] room;
    logic [15:0] v16;
    logic        in_chunk;
    logic        fill_req, word_req, pal_req, done_req, err_req;
    logic [24:0] fill_addr;
    logic [20:0] fill_n;
    logic [7:0]  fill_val;
    logic [19:0] word_addr, pal_addr;
    logic [7:0]  word_n;
    logic [15:0] word_val;
    logic [7:0]  pr, pg, pb;
    logic [2:0]  err_code;
    logic        dl_pkt, dl_eol, br_after, br_eol, do_end, do_next;
    logic [8:0]  dbl_n;
    logic [20:0] fill_room;
    logic        fill_ok;
    t_res        prim, sec;
    logic        prim_v;

    assign w = (r_cfg_w > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_cfg_w;
    assign h = (r_cfg_h > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : r_cfg_h;
    assign fa_new  = r_fa | (32'(i_byte) << {r_fbi[1:0], 3'b000});
    assign fbi_inc = r_fbi + 3'd1;
    assign v16     = fa_new[15:0];
    assign a       = 25'(r_lb) + 25'(r_col);
    assign room    = r_bsz - a[20:0];
    assign dbl_n   = {r_lit, 1'b0};

    always_comb begin
        n_ph = r_ph; n_fbl = r_fbl; n_cbl = r_cbl; n_fa = r_fa; n_chl = r_chl;
        n_lines = r_lines; n_pk = r_pk; n_pal = r_pal; n_hold = r_hold; n_ck = r_ck;
        n_fbi = r_fbi; n_lb = r_lb; n_col = r_col; n_lit = r_lit; n_err = r_err;
        fill_req = 1'b0; fill_addr = '0; fill_n = '0; fill_val = '0;
        word_req = 1'b0; word_addr = '0; word_n = '0; word_val = '0;
        pal_req = 1'b0; pal_addr = '0; pr = '0; pg = '0; pb = '0;
        done_req = 1'b0; err_req = 1'b0; err_code = ERR_FRAME_TYPE;
        dl_pkt = 1'b0; dl_eol = 1'b0; br_after = 1'b0; br_eol = 1'b0;
        do_end = 1'b0; do_next = 1'b0;
        in_chunk = r_ph >= PH_SKIP;
        if (i_valid && !r_err) begin
            if (in_chunk) begin
                if (n_cbl != 0) n_cbl = n_cbl - 32'd1;
                if (n_fbl != 0) n_fbl = n_fbl - 32'd1;
            end
            unique case (r_ph)
                PH_FH_SIZE, PH_CH_SIZE: begin
                    if (r_ph == PH_CH_SIZE && n_fbl != 0) n_fbl = n_fbl - 32'd1;
                    n_fa = fa_new; n_fbi = fbi_inc;
                    if (fbi_inc == 3'd4) begin
                        n_fa = '0; n_fbi = '0;
                        if (r_ph == PH_FH_SIZE) begin
                            n_fbl = fa_new; n_ph = PH_FH_TYPE;
                        end else begin
                            n_cbl = fa_new; n_ph = PH_CH_TYPE;
                        end
                    end
                end
                PH_FH_TYPE, PH_FH_COUNT, PH_CH_TYPE, PH_COL_COUNT, PH_DL_LINES,
                PH_DL_OPT: begin
                    if (r_ph == PH_CH_TYPE && n_fbl != 0) n_fbl = n_fbl - 32'd1;
                    n_fa = fa_new; n_fbi = fbi_inc;
                    if (fbi_inc == 3'd2) begin
                        n_fa = '0; n_fbi = '0;
                        case (r_ph)
                            PH_FH_TYPE: begin
                                n_hold = v16; n_ph = PH_FH_COUNT;
                            end
                            PH_FH_COUNT: begin
                                n_chl = v16[15] ? 16'd0 : v16;
                                if (r_hold != 16'hF1FA && r_hold != 16'hF100) begin
                                    err_req = 1'b1; err_code = ERR_FRAME_TYPE;
                                end else if (r_fbl[31] || r_fbl < 32'd16) begin
                                    err_req = 1'b1; err_code = ERR_FRAME_SHORT;
                                end else begin
                                    n_fbl = r_fbl - 32'd16; n_ph = PH_FH_RESV;
                                end
                            end
                            PH_CH_TYPE: begin
                                if (r_cbl[31] || r_cbl < 32'd6) begin
                                    err_req = 1'b1; err_code = ERR_CHUNK_SHORT;
                                end else if (r_cbl - 32'd6 > n_fbl) begin
                                    err_req = 1'b1; err_code = ERR_CHUNK_PAST;
                                end else begin
                                    n_cbl = r_cbl - 32'd6;
                                    n_lb = '0; n_col = '0; n_pal = '0;
                                    n_ph = PH_SKIP;
                                    case (v16)
                                        16'd4: begin n_ck = CK_C256; n_ph = PH_COL_COUNT; end
                                        16'd11: begin n_ck = CK_C64; n_ph = PH_COL_COUNT; end
                                        16'd7: begin n_ck = CK_DELTA; n_ph = PH_DL_LINES; end
                                        16'd15: begin
                                            n_ck = CK_BRUN; n_lines = 16'(h);
                                            if (h != 0) n_ph = PH_BR_LINE;
                                        end
                                        16'd16: begin
                                            n_ck = CK_LIT;
                                            if (r_bsz != 0 && n_cbl >= 32'(r_bsz))
                                                n_ph = PH_LITERAL;
                                        end
                                        16'd13: begin
                                            n_ck = CK_BLACK; fill_req = 1'b1;
                                            fill_n = r_bsz;
                                        end
                                        default: n_ck = CK_OTHER;
                                    endcase
                                    if (n_cbl == 0) do_end = 1'b1;
                                end
                            end
                            PH_COL_COUNT, PH_DL_LINES: begin
                                if (v16 == 0 || v16[15]) n_ph = PH_SKIP;
                                else if (r_ph == PH_COL_COUNT) begin
                                    n_pk = v16; n_ph = PH_COL_SKIP;
                                end else begin
                                    n_lines = v16; n_ph = PH_DL_OPT;
                                end
                            end
                            default: begin
                                if (v16[15]) begin
                                    if (v16[14])
                                        n_lb = f_sat(28'(r_lb) + 28'((17'h10000
                                            - 17'(v16)) * 17'(w)));
                                    else if (w != 0) begin
                                        fill_req = 1'b1;
                                        fill_addr = 25'(r_lb) + 25'(w) - 25'd1;
                                        fill_n = 21'd1; fill_val = v16[7:0];
                                    end
                                end else begin
                                    n_pk = v16; n_col = '0;
                                    if (v16 == 0) dl_eol = 1'b1;
                                    else n_ph = PH_DL_COLSKIP;
                                end
                            end
                        endcase
                    end
                end
                PH_FH_RESV: begin
                    if (r_fbi == 3'd7) begin
                        n_fbi = '0; do_next = 1'b1;
                    end else n_fbi = fbi_inc;
                end
                PH_FRAME_TAIL: begin
                    if (n_fbl != 0) n_fbl = n_fbl - 32'd1;
                    if (n_fbl == 0) begin
                        done_req = 1'b1; n_ph = PH_FH_SIZE; n_fa = '0; n_fbi = '0;
                    end
                end
                PH_SKIP: ;
                PH_LITERAL: begin
                    fill_req = 1'b1; fill_addr = 25'(r_lb); fill_n = 21'd1;
                    fill_val = i_byte;
                    n_lb = f_sat(28'(r_lb) + 28'd1);
                    if (25'(n_lb) >= 25'(r_bsz)) n_ph = PH_SKIP;
                end
                PH_COL_SKIP: begin
                    n_pal = (17'(r_pal) + 17'(i_byte) > 17'hFFFF) ? 16'hFFFF
                          : r_pal + 16'(i_byte);
                    n_ph = PH_COL_NUM;
                end
                PH_COL_NUM: begin
                    n_lines = (i_byte != 0) ? 16'(i_byte) : 16'(PALETTE_ENTRIES);
                    n_fbi = '0; n_ph = PH_COL_RGB;
                end
                PH_COL_RGB: begin
                    if (r_fbi == 3'd0) begin
                        n_hold = 16'(i_byte); n_fbi = 3'd1;
                    end else if (r_fbi == 3'd1) begin
                        n_hold = r_hold | {i_byte, 8'h00}; n_fbi = 3'd2;
                    end else begin
                        n_fbi = '0;
                        pal_req = r_pal < 16'(PALETTE_ENTRIES);
                        pal_addr = 20'(r_pal);
                        if (r_ck == CK_C256) begin
                            pr = r_hold[7:0] >> 2; pg = r_hold[15:8] >> 2; pb = i_byte >> 2;
                        end else begin
                            pr = r_hold[7:0]; pg = r_hold[15:8]; pb = i_byte;
                        end
                        if (r_pal < 16'hFFFF) n_pal = r_pal + 16'd1;
                        if (n_lines != 0) n_lines = n_lines - 16'd1;
                        if (n_lines == 0) begin
                            if (n_pk != 0) n_pk = n_pk - 16'd1;
                            n_ph = (n_pk == 0) ? PH_SKIP : PH_COL_SKIP;
                        end
                    end
                end
                PH_DL_COLSKIP: begin
                    n_col = f_sat(28'(r_col) + 28'(i_byte));
                    n_ph = PH_DL_TYPE;
                end
                PH_DL_TYPE: begin
                    if (!i_byte[7]) begin
                        n_lit = {i_byte[6:0], 1'b0};
                        if (i_byte == 0) dl_pkt = 1'b1;
                        else n_ph = PH_DL_LIT;
                    end else begin
                        n_lit = 8'(9'd256 - 9'(i_byte)); n_fbi = '0; n_ph = PH_DL_WORD;
                    end
                end
                PH_DL_LIT, PH_BR_LIT: begin
                    fill_req = 1'b1; fill_addr = a; fill_n = 21'd1; fill_val = i_byte;
                    n_col = f_sat(28'(r_col) + 28'd1);
                    if (r_lit != 0) n_lit = r_lit - 8'd1;
                    if (n_lit == 0) begin
                        if (r_ph == PH_DL_LIT) dl_pkt = 1'b1;
                        else br_after = 1'b1;
                    end
                end
                PH_DL_WORD: begin
                    if (r_fbi == 3'd0) begin
                        n_hold = 16'(i_byte); n_fbi = 3'd1;
                        if (n_cbl != 0 && a < 25'(r_bsz) && 21'(dbl_n) > room && room[0]) begin
                            fill_req = 1'b1; fill_addr = a + 25'({room[20:1], 1'b0});
                            fill_n = 21'd1; fill_val = i_byte;
                        end
                    end else begin
                        n_fbi = '0;
                        if (a < 25'(r_bsz)) begin
                            word_n = (21'(dbl_n) <= room) ? r_lit : 8'(room[20:1] > 20'd255
                                     ? 20'd255 : room[20:1]);
                            word_req = word_n != 0;
                            word_addr = a[19:0];
                            word_val = {i_byte, r_hold[7:0]};
                        end
                        n_col = f_sat(28'(r_col) + 28'(dbl_n));
                        dl_pkt = 1'b1;
                    end
                end
                PH_BR_LINE: begin
                    n_col = '0;
                    if (w == 0) br_eol = 1'b1;
                    else n_ph = PH_BR_SIZE;
                end
                PH_BR_SIZE: begin
                    if (!i_byte[7]) begin
                        n_lit = i_byte; n_ph = PH_BR_COLOR;
                    end else begin
                        n_lit = 8'(9'd256 - 9'(i_byte)); n_ph = PH_BR_LIT;
                    end
                end
                PH_BR_COLOR: begin
                    fill_req = 1'b1; fill_addr = a; fill_n = 21'(r_lit); fill_val = i_byte;
                    n_col = f_sat(28'(r_col) + 28'(r_lit));
                    br_after = 1'b1;
                end
                default: n_ph = PH_SKIP;
            endcase
            if (dl_pkt) begin
                if (n_pk != 0) n_pk = n_pk - 16'd1;
                if (n_pk == 0) dl_eol = 1'b1;
                else n_ph = PH_DL_COLSKIP;
            end
            if (br_after) begin
                if (n_col >= 24'(w)) br_eol = 1'b1;
                else n_ph = PH_BR_SIZE;
            end
            if (dl_eol || br_eol) begin
                n_lb = f_sat(28'(n_lb) + 28'(w));
                if (n_lines != 0) n_lines = n_lines - 16'd1;
                n_ph = (n_lines == 0) ? PH_SKIP : (dl_eol ? PH_DL_OPT : PH_BR_LINE);
            end
            if (err_req) n_err = 1'b1;
            if (in_chunk && !n_err && n_cbl == 0) do_end = 1'b1;
            if (do_end) begin
                if (n_chl != 0) n_chl = n_chl - 16'd1;
                do_next = 1'b1;
            end
            if (do_next) begin
                if (n_chl != 0) begin
                    if (n_fbl < 32'd6) begin
                        err_req = 1'b1; err_code = ERR_HDR_PAST; n_err = 1'b1;
                    end else n_ph = PH_CH_SIZE;
                end else if (n_fbl == 0) begin
                    done_req = 1'b1; n_ph = PH_FH_SIZE; n_fa = '0; n_fbi = '0;
                end else n_ph = PH_FRAME_TAIL;
            end
        end
    end

    assign fill_room = r_bsz - fill_addr[20:0];
    assign fill_ok   = fill_req && fill_addr < 25'(r_bsz) && fill_n != 0;

    always_comb begin
        prim = '0;
        sec  = '0;
        prim_v = 1'b1;
        if (fill_ok) begin
            prim.kind = KIND_FILL; prim.address = fill_addr[19:0];
            prim.count = (fill_n > fill_room) ? fill_room : fill_n;
            prim.fill_value = 16'(fill_val);
        end else if (word_req) begin
            prim.kind = KIND_WORD; prim.address = word_addr;
            prim.count = 21'(word_n); prim.fill_value = word_val;
        end else if (pal_req) begin
            prim.kind = KIND_PAL; prim.address = pal_addr;
            prim.red = pr; prim.green = pg; prim.blue = pb;
        end else prim_v = 1'b0;
        sec.kind = err_req ? KIND_ERROR : KIND_DONE;
        sec.error_code = err_req ? err_code : 3'd0;
        sec.last_of_item = 1'b1;
        o_res = '0;
        if (prim_v) begin
            o_res.r0 = prim;
            o_res.r0.last_of_item = !(done_req || err_req);
            o_res.num = 2'd1;
            if (done_req || err_req) begin
                o_res.r1 = sec; o_res.num = 2'd2;
            end
        end else if (done_req || err_req) begin
            o_res.r0 = sec; o_res.num = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_FH_SIZE; r_fbl <= '0; r_cbl <= '0; r_chl <= '0; r_ck <= '0;
            r_fa <= '0; r_fbi <= '0; r_lines <= '0; r_pk <= '0; r_lb <= '0;
            r_col <= '0; r_lit <= '0; r_pal <= '0; r_hold <= '0; r_err <= 1'b0;
            r_cfg_w <= 11'd320; r_cfg_h <= 11'd200; r_bsz <= 21'd64000;
        end else begin
            r_ph <= n_ph; r_fbl <= n_fbl; r_cbl <= n_cbl; r_chl <= n_chl; r_ck <= n_ck;
            r_fa <= n_fa; r_fbi <= n_fbi; r_lines <= n_lines; r_pk <= n_pk; r_lb <= n_lb;
            r_col <= n_col; r_lit <= n_lit; r_pal <= n_pal; r_hold <= n_hold;
            r_err <= n_err;
            r_bsz <= 21'(w) * 21'(h);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) r_cfg_w <= i_cfg_data;
                if (i_cfg_index == CFG_HEIGHT) r_cfg_h <= i_cfg_data;
            end
        end
    end

    ap_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err) else $error("error flag cleared");
    ap_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> o_res.num == 2'd0) else $error("word produced after error");
    ap_err_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_err && n_err) |-> (o_res.num != 2'd0)) else $error("error not reported");
    ap_pair_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.num == 2'd2 |-> (o_res.r1.kind == KIND_DONE || o_res.r1.kind == KIND_ERROR))
        else $error("second word not done or error");

endmodule

>>> hw/rtl/fcd_res_queue.sv
module fcd_res_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fcd_pkg::t_res_pair           i_push,
    output fcd_pkg::t_res                o_head,
    output logic                         o_valid,
    input  logic                         i_pop,
    output logic [fcd_pkg::Q_CNT_W-1:0]  o_count
);
    import fcd_pkg::*;

    t_res                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_rd, r_wr;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                pop;

    assign o_valid = r_cnt != 0;
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.num == 2'd2) r_mem[Q_PTR_W'(r_wr + 1'b1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_PTR_W'(i_push.num);
            r_rd  <= r_rd + Q_PTR_W'(pop);
            r_cnt <= r_cnt + Q_CNT_W'(i_push.num) - Q_CNT_W'(pop);
        end
    end

    ap_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH)) else $error("result queue overflow");
    ap_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> (r_cnt + Q_CNT_W'(i_push.num) <= Q_CNT_W'(Q_DEPTH)))
        else $error("push without room");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop) |=> o_valid) else $error("queued word lost");

endmodule

>>> hw/rtl/flic_frame_chunk_decoder.sv
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata[7:0] data_byte
// m_axis  | out | m_axis_tvalid/tready    | tuser kind, tdata fields, tlast last_of_item
// cfg     | in  | i_cfg_we                | i_cfg_index (0 width, 1 height), i_cfg_data
// One byte a cycle when the output side keeps up; each byte is held in the input
// register, then its words enter an eight-word result queue.
// Each byte yields up to two words; tready falls while the queue cannot take two more.
// Synchronous active-low reset; no clearing pass, block is ready right after reset.
module flic_frame_chunk_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [19:0] address, [40:20] count, [56:41] fill_value, [64:57] red,
    // [72:65] green, [80:73] blue, [83:81] error_code, [87:84] zero
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last_of_item
);
    import fcd_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    t_res_pair          res;
    t_res               head;
    logic [Q_CNT_W-1:0] q_count;

    assign s_axis_tready = (Q_CNT_W'(q_count) + (r_in_valid ? Q_CNT_W'(2) : Q_CNT_W'(0)))
                           <= Q_CNT_W'(Q_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_valid <= 1'b0;
        else          r_in_valid <= s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_byte <= s_axis_tdata;
    end

    fcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .o_res       (res)
    );

    fcd_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_head  (head),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_count (q_count)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_item;
    assign m_axis_tdata = {4'b0000, head.error_code, head.blue, head.green, head.red,
                           head.fill_value, head.count, head.address};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import fcd_pkg::*;

    localparam int PH_FH_SIZE    = 0;
    localparam int PH_FH_TYPE    = 1;
    localparam int PH_FH_COUNT   = 2;
    localparam int PH_FH_RESV    = 3;
    localparam int PH_CH_SIZE    = 4;
    localparam int PH_CH_TYPE    = 5;
    localparam int PH_FRAME_TAIL = 6;
    localparam int PH_SKIP       = 7;
    localparam int PH_COL_COUNT  = 8;
    localparam int PH_COL_SKIP   = 9;
    localparam int PH_COL_NUM    = 10;
    localparam int PH_COL_RGB    = 11;
    localparam int PH_DL_LINES   = 12;
    localparam int PH_DL_OPT     = 13;
    localparam int PH_DL_COLSKIP = 14;
    localparam int PH_DL_TYPE    = 15;
    localparam int PH_DL_LIT     = 16;
    localparam int PH_DL_WORD    = 17;
    localparam int PH_BR_LINE    = 18;
    localparam int PH_BR_SIZE    = 19;
    localparam int PH_BR_COLOR   = 20;
    localparam int PH_BR_LIT     = 21;
    localparam int PH_LITERAL    = 22;

    localparam int CK_OTHER    = 0;
    localparam int CK_COLOR256 = 1;
    localparam int CK_COLOR64  = 2;
    localparam int CK_DELTA    = 3;
    localparam int CK_BYTERUN  = 4;
    localparam int CK_LITERAL  = 5;
    localparam int CK_BLACK    = 6;

    localparam int CT_COLOR256 = 4;
    localparam int CT_COLOR64  = 11;
    localparam int CT_DELTA    = 7;
    localparam int CT_BYTERUN  = 15;
    localparam int CT_LITERAL  = 16;
    localparam int CT_BLACK    = 13;
    localparam int CT_UNKNOWN  = 5;

    localparam int FT_MAIN = 'hF1FA;
    localparam int FT_ALT  = 'hF100;
    localparam longint unsigned POS_CAP = 64'hFFFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [19:0] address;
        logic [20:0] count;
        logic [15:0] fill_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  error_code;
        logic        last_of_item;
    } dec_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    flic_frame_chunk_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    dec_word_t   pending_words[$];
    dec_word_t   step_words[$];
    bit [7:0]    frame_buf[$];
    bit [7:0]    chunk_buf[$];
    bit [7:0]    body[$];
    int          mismatches = 0;
    int          failures = 0;
    int          bytes_sent = 0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int          rx_hold_req = 0;
    int          rx_hold = 0;
    int          rx_gap = 0;

    int unsigned cfg_w, cfg_h;
    int unsigned ph, fbl, cbl, chl, ck, fa, fbi, ll, pl, lb, co, lit, pe, chold;
    bit          err_seen;

    function automatic longint unsigned eff_w();
        return cfg_w > MAX_WIDTH ? MAX_WIDTH : cfg_w;
    endfunction

    function automatic longint unsigned eff_h();
        return cfg_h > MAX_HEIGHT ? MAX_HEIGHT : cfg_h;
    endfunction

    function automatic longint unsigned buf_pixels();
        return eff_w() * eff_h();
    endfunction

    function automatic int unsigned sat_pos(longint unsigned v);
        return v > POS_CAP ? POS_CAP : v;
    endfunction

    function automatic void emit(int unsigned k, longint unsigned a, longint unsigned c,
                                 int unsigned v, int unsigned r, int unsigned g,
                                 int unsigned bl, int unsigned e);
        dec_word_t w;
        if (step_words.size() >= 2) return;
        w.kind = k[2:0];
        w.address = a[19:0];
        w.count = c[20:0];
        w.fill_value = v[15:0];
        w.red = r[7:0];
        w.green = g[7:0];
        w.blue = bl[7:0];
        w.error_code = e[2:0];
        w.last_of_item = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void byte_fill(longint unsigned a, longint unsigned n, int unsigned v);
        longint unsigned bsz;
        bsz = buf_pixels();
        if (a >= bsz || n == 0) return;
        if (n > bsz - a) n = bsz - a;
        emit(KIND_FILL, a, n, v, 0, 0, 0, 0);
    endfunction

    function automatic bit take_field(int unsigned b, int unsigned n, output int unsigned v);
        fa |= b << ((fbi & 3) * 8);
        fbi++;
        v = fa;
        if (fbi < n) return 1'b0;
        fa = 0;
        fbi = 0;
        return 1'b1;
    endfunction

    function automatic void raise_error(int unsigned code);
        err_seen = 1'b1;
        emit(KIND_ERROR, 0, 0, 0, 0, 0, 0, code);
    endfunction

    function automatic void begin_frame();
        ph = PH_FH_SIZE;
        fa = 0;
        fbi = 0;
    endfunction

    function automatic void next_chunk();
        if (chl > 0) begin
            if (fbl < 6) raise_error(ERR_HDR_PAST);
            else ph = PH_CH_SIZE;
        end else if (fbl == 0) begin
            emit(KIND_DONE, 0, 0, 0, 0, 0, 0, 0);
            begin_frame();
        end else begin
            ph = PH_FRAME_TAIL;
        end
    endfunction

    function automatic void end_chunk();
        if (chl > 0) chl--;
        next_chunk();
    endfunction

    function automatic void start_chunk(int unsigned t);
        longint unsigned bsz;
        bsz = buf_pixels();
        lb = 0;
        co = 0;
        pe = 0;
        fa = 0;
        fbi = 0;
        ph = PH_SKIP;
        case (t)
            CT_COLOR256: begin ck = CK_COLOR256; ph = PH_COL_COUNT; end
            CT_COLOR64:  begin ck = CK_COLOR64; ph = PH_COL_COUNT; end
            CT_DELTA:    begin ck = CK_DELTA; ph = PH_DL_LINES; end
            CT_BYTERUN: begin
                ck = CK_BYTERUN;
                ll = eff_h();
                if (ll > 0) ph = PH_BR_LINE;
            end
            CT_LITERAL: begin
                ck = CK_LITERAL;
                if (bsz > 0 && longint'(cbl) >= bsz) ph = PH_LITERAL;
            end
            CT_BLACK: begin ck = CK_BLACK; byte_fill(0, bsz, 0); end
            default: ck = CK_OTHER;
        endcase
    endfunction

    function automatic void dl_end_line();
        lb = sat_pos(longint'(lb) + eff_w());
        if (ll > 0) ll--;
        ph = ll == 0 ? PH_SKIP : PH_DL_OPT;
    endfunction

    function automatic void dl_packet_done();
        if (pl > 0) pl--;
        if (pl == 0) dl_end_line();
        else ph = PH_DL_COLSKIP;
    endfunction

    function automatic void br_end_line();
        lb = sat_pos(longint'(lb) + eff_w());
        if (ll > 0) ll--;
        ph = ll == 0 ? PH_SKIP : PH_BR_LINE;
    endfunction

    function automatic void br_after_packet();
        if (co >= eff_w()) br_end_line();
        else ph = PH_BR_SIZE;
    endfunction

    function automatic void step_color(int unsigned b);
        int unsigned v, s;
        case (ph)
            PH_COL_COUNT: begin
                if (take_field(b, 2, v)) begin
                    if (v == 0 || (v & 'h8000)) ph = PH_SKIP;
                    else begin pl = v; ph = PH_COL_SKIP; end
                end
            end
            PH_COL_SKIP: begin
                pe += b;
                if (pe > 'hFFFF) pe = 'hFFFF;
                ph = PH_COL_NUM;
            end
            PH_COL_NUM: begin
                ll = b ? b : PALETTE_ENTRIES;
                fbi = 0;
                ph = PH_COL_RGB;
            end
            default: begin
                if (fbi == 0) begin
                    chold = b;
                    fbi = 1;
                end else if (fbi == 1) begin
                    chold |= b << 8;
                    fbi = 2;
                end else begin
                    fbi = 0;
                    s = ck == CK_COLOR256 ? 2 : 0;
                    if (pe < PALETTE_ENTRIES)
                        emit(KIND_PAL, pe, 0, 0, (chold & 'hFF) >> s,
                             ((chold >> 8) & 'hFF) >> s, b >> s, 0);
                    if (pe < 'hFFFF) pe++;
                    if (ll > 0) ll--;
                    if (ll == 0) begin
                        if (pl > 0) pl--;
                        ph = pl == 0 ? PH_SKIP : PH_COL_SKIP;
                    end
                end
            end
        endcase
    endfunction

    function automatic void step_delta(int unsigned b);
        int unsigned v;
        longint unsigned w, a, bsz, n, words;
        w = eff_w();
        a = longint'(lb) + co;
        bsz = buf_pixels();
        case (ph)
            PH_DL_LINES: begin
                if (take_field(b, 2, v)) begin
                    if (v == 0 || (v & 'h8000)) ph = PH_SKIP;
                    else begin ll = v; ph = PH_DL_OPT; end
                end
            end
            PH_DL_OPT: begin
                if (take_field(b, 2, v)) begin
                    if (v & 'h8000) begin
                        if (v & 'h4000)
                            lb = sat_pos(longint'(lb) + longint'('h10000 - v) * w);
                        else if (w > 0)
                            byte_fill(longint'(lb) + w - 1, 1, v & 'hFF);
                    end else begin
                        pl = v;
                        co = 0;
                        if (v == 0) dl_end_line();
                        else ph = PH_DL_COLSKIP;
                    end
                end
            end
            PH_DL_COLSKIP: begin
                co = sat_pos(longint'(co) + b);
                ph = PH_DL_TYPE;
            end
            PH_DL_TYPE: begin
                if (b < 'h80) begin
                    lit = 2 * b;
                    if (lit == 0) dl_packet_done();
                    else ph = PH_DL_LIT;
                end else begin
                    lit = 256 - b;
                    fbi = 0;
                    ph = PH_DL_WORD;
                end
            end
            PH_DL_LIT: begin
                byte_fill(a, 1, b);
                co = sat_pos(longint'(co) + 1);
                if (lit > 0) lit--;
                if (lit == 0) dl_packet_done();
            end
            default: begin
                n = lit;
                if (fbi == 0) begin
                    chold = b;
                    fbi = 1;
                    if (cbl > 0 && a < bsz && 2 * n > bsz - a && ((bsz - a) & 1))
                        byte_fill(a + ((bsz - a) & ~64'd1), 1, b);
                end else begin
                    fbi = 0;
                    if (a < bsz) begin
                        words = (2 * n <= bsz - a) ? n : (bsz - a) / 2;
                        if (words > 0) emit(KIND_WORD, a, words, chold | (b << 8), 0, 0, 0, 0);
                    end
                    co = sat_pos(longint'(co) + 2 * n);
                    dl_packet_done();
                end
            end
        endcase
    endfunction

    function automatic void step_byterun(int unsigned b);
        longint unsigned a;
        a = longint'(lb) + co;
        case (ph)
            PH_BR_LINE: begin
                co = 0;
                if (eff_w() == 0) br_end_line();
                else ph = PH_BR_SIZE;
            end
            PH_BR_SIZE: begin
                if (b < 'h80) begin lit = b; ph = PH_BR_COLOR; end
                else begin lit = 256 - b; ph = PH_BR_LIT; end
            end
            PH_BR_COLOR: begin
                byte_fill(a, lit, b);
                co = sat_pos(longint'(co) + lit);
                br_after_packet();
            end
            default: begin
                byte_fill(a, 1, b);
                co = sat_pos(longint'(co) + 1);
                if (lit > 0) lit--;
                if (lit == 0) br_after_packet();
            end
        endcase
    endfunction

    function automatic void decode_byte(bit [7:0] din);
        int unsigned b, v, ph_now;
        bit          in_chunk;
        b = din;
        ph_now = ph;
        in_chunk = ph_now >= PH_SKIP;
        step_words.delete();
        if (err_seen) return;
        if (in_chunk) begin
            if (cbl > 0) cbl--;
            if (fbl > 0) fbl--;
        end
        case (ph_now)
            PH_FH_SIZE: if (take_field(b, 4, v)) begin fbl = v; ph = PH_FH_TYPE; end
            PH_FH_TYPE: if (take_field(b, 2, v)) begin chold = v; ph = PH_FH_COUNT; end
            PH_FH_COUNT: begin
                if (take_field(b, 2, v)) begin
                    chl = (v & 'h8000) ? 0 : v;
                    if (chold != FT_MAIN && chold != FT_ALT) raise_error(ERR_FRAME_TYPE);
                    else if ((fbl & 'h80000000) || fbl < 16) raise_error(ERR_FRAME_SHORT);
                    else begin fbl -= 16; fbi = 0; ph = PH_FH_RESV; end
                end
            end
            PH_FH_RESV: begin
                fbi++;
                if (fbi >= 8) begin fbi = 0; next_chunk(); end
            end
            PH_CH_SIZE: begin
                if (fbl > 0) fbl--;
                if (take_field(b, 4, v)) begin cbl = v; ph = PH_CH_TYPE; end
            end
            PH_CH_TYPE: begin
                if (fbl > 0) fbl--;
                if (take_field(b, 2, v)) begin
                    if ((cbl & 'h80000000) || cbl < 6) raise_error(ERR_CHUNK_SHORT);
                    else if (cbl - 6 > fbl) raise_error(ERR_CHUNK_PAST);
                    else begin
                        cbl -= 6;
                        start_chunk(v);
                        if (cbl == 0) end_chunk();
                    end
                end
            end
            PH_FRAME_TAIL: begin
                if (fbl > 0) fbl--;
                if (fbl == 0) begin
                    emit(KIND_DONE, 0, 0, 0, 0, 0, 0, 0);
                    begin_frame();
                end
            end
            PH_SKIP: ;
            PH_LITERAL: begin
                byte_fill(lb, 1, b);
                lb = sat_pos(longint'(lb) + 1);
                if (longint'(lb) >= buf_pixels()) ph = PH_SKIP;
            end
            default: begin
                if (ph_now <= PH_COL_RGB) step_color(b);
                else if (ph_now <= PH_DL_WORD) step_delta(b);
                else if (ph_now <= PH_BR_LIT) step_byterun(b);
                else ph = PH_SKIP;
            end
        endcase
        if (in_chunk && !err_seen && cbl == 0) end_chunk();
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_item = 1'b1;
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    // Output side: check each word, then decide tready for the next edge.
    always @(posedge i_clk) begin
        dec_word_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.address = m_axis_tdata[19:0];
            got.count = m_axis_tdata[40:20];
            got.fill_value = m_axis_tdata[56:41];
            got.red = m_axis_tdata[64:57];
            got.green = m_axis_tdata[72:65];
            got.blue = m_axis_tdata[80:73];
            got.error_code = m_axis_tdata[83:81];
            got.last_of_item = m_axis_tlast;
            if (pending_words.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", got);
            end else begin
                want = pending_words.pop_front();
                if (got != want) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (rx_hold_req > 0) begin
            rx_hold = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(bit [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(bit idx, int unsigned val);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[10:0];
        @(posedge i_clk);
        if (idx == CFG_WIDTH) cfg_w = val & 'h7FF;
        else cfg_h = val & 'h7FF;
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
    endtask

    function automatic void put8(int unsigned v);
        body.push_back(v[7:0]);
    endfunction

    function automatic void put16(int unsigned v);
        put8(v);
        put8(v >> 8);
    endfunction

    function automatic void put_rand(int n);
        repeat (n) put8($urandom);
    endfunction

    function automatic int unsigned odd_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 'h8000 | $urandom_range(0, 'h7FFF);
        return $urandom_range(1, 3);
    endfunction

    function automatic void gen_color();
        int unsigned np, num;
        np = odd_count();
        put16(np);
        if (np == 0 || np >= 'h8000) return;
        repeat (np) begin
            put8($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8));
            num = $urandom_range(0, 29) == 0 ? 0 : $urandom_range(1, 4);
            put8(num);
            put_rand(3 * (num == 0 ? PALETTE_ENTRIES : num));
        end
    endfunction

    function automatic void gen_delta();
        int unsigned nl, np, c;
        nl = odd_count();
        put16(nl);
        if (nl == 0 || nl >= 'h8000) return;
        repeat (nl) begin
            if ($urandom_range(0, 3) == 0) put16('h10000 - $urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0) put16('h8000 | $urandom_range(0, 255));
            np = $urandom_range(0, 3);
            put16(np);
            repeat (np) begin
                put8($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 6));
                if ($urandom_range(0, 1)) begin
                    c = $urandom_range(0, 3);
                    put8(c);
                    put_rand(2 * c);
                end else begin
                    c = $urandom_range(0, 7) == 0 ? 128 : $urandom_range(1, 4);
                    put8(256 - c);
                    put_rand(2);
                end
            end
        end
    endfunction

    function automatic void gen_byterun();
        int unsigned col, c, pk;
        int          lines;
        lines = eff_h() > 4 ? 4 : eff_h();
        repeat (lines) begin
            put8($urandom);
            col = 0;
            pk = 0;
            while (col < eff_w() && pk < 12) begin
                pk++;
                if ($urandom_range(0, 1)) begin
                    c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 5);
                    put8(c);
                    put8($urandom);
                end else begin
                    c = $urandom_range(0, 15) == 0 ? 128 : $urandom_range(1, 4);
                    put8(256 - c);
                    put_rand(c);
                end
                col += c;
            end
        end
    endfunction

    function automatic void gen_chunk(int ct);
        longint unsigned bsz;
        int          cut;
        body.delete();
        bsz = buf_pixels();
        case (ct)
            CT_COLOR256, CT_COLOR64: gen_color();
            CT_DELTA:   gen_delta();
            CT_BYTERUN: gen_byterun();
            CT_LITERAL: put_rand(bsz <= 64 ? bsz - $urandom_range(0, 1) : 20);
            CT_BLACK: ;
            default: put_rand($urandom_range(0, 5));
        endcase
        cut = $urandom_range(0, 9);
        if (cut == 0 && body.size() > 0)
            repeat ($urandom_range(1, body.size())) void'(body.pop_back());
        else if (cut == 1)
            put_rand($urandom_range(1, 3));
        put16(body.size() + 6);
        put16(0);
        chunk_buf.push_back(body[body.size() - 4]);
        chunk_buf.push_back(body[body.size() - 3]);
        chunk_buf.push_back(8'h00);
        chunk_buf.push_back(8'h00);
        chunk_buf.push_back(ct[7:0]);
        chunk_buf.push_back(ct[15:8]);
        for (int i = 0; i < body.size() - 4; i++) chunk_buf.push_back(body[i]);
    endfunction

    function automatic int pick_type();
        case ($urandom_range(0, 6))
            0: return CT_COLOR256;
            1: return CT_COLOR64;
            2: return CT_DELTA;
            3: return CT_BYTERUN;
            4: return CT_LITERAL;
            5: return CT_BLACK;
            default: return $urandom_range(0, 1) ? CT_UNKNOWN : $urandom_range(17, 65535);
        endcase
    endfunction

    // ct < 0 picks 0..3 random chunks; the declared count may fall short
    // of the chunks present, the rest then reads as frame tail.
    task automatic send_frame(int ct);
        int          nch, tail;
        int unsigned cnt, size;
        chunk_buf.delete();
        nch = ct >= 0 ? 1 : $urandom_range(0, 3);
        for (int i = 0; i < nch; i++) gen_chunk(ct >= 0 ? ct : pick_type());
        cnt = nch;
        if (ct < 0 && $urandom_range(0, 9) == 0)
            cnt = $urandom_range(0, 1) ? 'h8000 | $urandom_range(0, 'h7FFF) : nch > 0 ? nch - 1 : 0;
        tail = ct < 0 ? $urandom_range(0, 2) : 0;
        size = 16 + chunk_buf.size() + tail;
        body.delete();
        put16(size);
        put16(size >> 16);
        put16($urandom_range(0, 1) ? FT_MAIN : FT_ALT);
        put16(cnt);
        put_rand(8);
        foreach (chunk_buf[i]) body.push_back(chunk_buf[i]);
        put_rand(tail);
        frame_buf = body;
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
    endtask

    task automatic test_empty_frames();
        send_frame(-1);
        chunk_buf.delete();
        body.delete();
        put16(16);
        put16(0);
        put16(FT_ALT);
        put16('hFFFF);
        put_rand(8);
        frame_buf = body;
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
    endtask

    task automatic test_each_chunk();
        set_size(4, 3);
        send_frame(CT_COLOR256);
        send_frame(CT_COLOR64);
        send_frame(CT_DELTA);
        send_frame(CT_BYTERUN);
        send_frame(CT_LITERAL);
        send_frame(CT_BLACK);
        send_frame(CT_UNKNOWN);
    endtask

    task automatic test_size_extremes();
        set_size(1, 1);
        repeat (4) send_frame(-1);
        set_size(2047, 2047);
        send_frame(CT_BLACK);
        send_frame(CT_DELTA);
        send_frame(CT_BYTERUN);
        set_size(MAX_WIDTH, 1);
        send_frame(CT_BYTERUN);
        set_size(3, MAX_HEIGHT);
        send_frame(CT_DELTA);
    endtask

    task automatic test_backpressure();
        set_size(8, 4);
        wait_drain();
        rx_hold_req = 300;
        repeat (3) send_frame(CT_BYTERUN);
        wait_drain();
        send_frame(CT_COLOR64);
    endtask

    task automatic test_random_frames();
        int start;
        start = bytes_sent;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (bytes_sent - start < 400) begin
            if ($urandom_range(0, 7) == 0)
                set_size($urandom_range(0, 5) == 0 ? 320 : $urandom_range(1, 16),
                         $urandom_range(0, 5) == 0 ? 200 : $urandom_range(1, 8));
            send_frame(-1);
        end
    endtask

    task automatic test_quiet_frames();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_size(5, 2);
        repeat (6) send_frame(-1);
    endtask

    // Errors are sticky, so this runs last.
    task automatic test_error();
        int code;
        code = $urandom_range(0, 4);
        body.delete();
        case (code)
            ERR_FRAME_TYPE: begin put16(40); put16(0); put16('h1234); put16(1); end
            ERR_FRAME_SHORT: begin put16(8); put16(0); put16(FT_MAIN); put16(1); end
            ERR_HDR_PAST: begin put16(19); put16(0); put16(FT_MAIN); put16(1); end
            ERR_CHUNK_SHORT: begin put16(32); put16(0); put16(FT_MAIN); put16(1); end
            default: begin put16(22); put16(0); put16(FT_ALT); put16(1); end
        endcase
        put_rand(8);
        if (code == ERR_CHUNK_SHORT) begin put16(4); put16(0); put16(CT_DELTA); end
        if (code == ERR_CHUNK_PAST) begin put16(100); put16(0); put16(CT_BLACK); end
        put_rand(6);
        frame_buf = body;
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
    endtask

    initial begin
        cfg_w = 320;
        cfg_h = 200;
        ph = PH_FH_SIZE;
        {fbl, cbl, chl, ck, fa, fbi, ll, pl, lb, co, lit, pe, chold} = '0;
        err_seen = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_frames();
        test_each_chunk();
        test_size_extremes();
        test_backpressure();
        test_random_frames();
        test_quiet_frames();
        test_error();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0 && pending_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
